/* src/trt_pkg.sv */
// ============================================================================
// trt_pkg - shared types and constants for the thermistor converter
// Widths, status codes, fixed-point constants and the coefficient bank type.
// ============================================================================
`default_nettype none

package trt_pkg;

   localparam int POLY_DEGREE_DEF  = 3;
   localparam int LN_FRAC_BITS_DEF = 24;

   localparam int R_W       = 24;   // resistance field
   localparam int TEMP_W    = 17;   // temperature field
   localparam int STAT_W    = 2;
   localparam int COEF_W    = 48;
   localparam int NUM_COEF  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int K_W       = 5;    // top-bit position of the resistance
   localparam int XINT_W    = 5;    // integer bits of ln r
   localparam int LOG_STEPS = 32;   // fraction bits of log2
   localparam int MAG_W     = 62;   // accumulator magnitude
   localparam int ACC_W     = 64;
   localparam int Q_W       = 17;   // quotient bits kept
   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0]       LN2_Q32    = 32'd2977044472;
   localparam logic [58:0]       INV_NUM    = 59'd450359962737049600;
   localparam logic [MAG_W-1:0]  ACC_CAP    = {MAG_W{1'b1}};
   localparam logic [Q_W-1:0]    KELVIN_OFS = 17'd27315;
   localparam logic [Q_W-1:0]    Q_SAT      = 17'd92850;
   localparam logic [TEMP_W-1:0] TEMP_MAX   = 17'd65535;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_ZERO = 2'd1,
      ST_NPOS = 2'd2,
      ST_SAT  = 2'd3
   } status_type;

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_type;

   localparam coef_bank_type COEF_RESET = {
      48'd416381910,
      48'(-48'sd785297806),
      48'd1063515902201,
      48'd5051040142643
   };

   // per-item control that travels with the data
   typedef struct packed {
      logic valid;
      logic zero;
   } tag_type;

endpackage

`default_nettype wire

/* src/thermistor_resistance_to_temperature_core.sv */
// ============================================================================
// thermistor_resistance_to_temperature_core - NTC ohms to 0.01 degC
// Cubic Steinhart-Hart conversion, fully pipelined, one transaction per clock.
// ============================================================================
// Usage: pulse start with req_resistance_ohm whenever busy is low; while it
// stays low, one transaction can be issued every clock. Each transaction
// returns exactly one result, in issue order, on rsp_temp_centi_c / rsp_status
// for one cycle marked by rsp_strobe. The result side cannot stall, so capture
// it when strobed. The pipeline holds the 32 squaring stages of the log, three
// stages per Horner step and the 17-stage quotient pipeline. Write the
// coefficient registers only with no transaction in flight.
`default_nettype none

module thermistor_resistance_to_temperature_core #(
   parameter int POLY_DEGREE  = trt_pkg::POLY_DEGREE_DEF,
   parameter int LN_FRAC_BITS = trt_pkg::LN_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [trt_pkg::R_W-1:0]           req_resistance_ohm,
   // response
   output logic                                   rsp_strobe,
   output logic signed [trt_pkg::TEMP_W-1:0]      rsp_temp_centi_c,
   output logic [trt_pkg::STAT_W-1:0]             rsp_status,
   // coefficient registers
   input  wire logic                              csr_we,
   input  wire logic [trt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [trt_pkg::COEF_W-1:0]        csr_wdata
);

   localparam int XW = trt_pkg::XINT_W + LN_FRAC_BITS;

   // coefficient bank, Q.52 signed
   trt_pkg::coef_bank_type coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= trt_pkg::COEF_RESET;
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // front: classify and take the log
   trt_pkg::tag_type  f_tag, q_tag;
   logic [XW-1:0]     f_x, q_x;
   logic              q_full;
   logic              accept;
   logic [trt_pkg::TEMP_W-1:0] temp_raw;

   assign accept = start && !busy;
   assign busy   = q_full;

   trt_front #(
      .LN_FRAC_BITS (LN_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_r     (req_resistance_ohm),
      .out_tag  (f_tag),
      .out_x    (f_x)
   );

   // decoupling queue; back end drains it every cycle
   trt_queue #(
      .XW (XW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (f_tag),
      .in_x     (f_x),
      .out_take (1'b1),
      .out_tag  (q_tag),
      .out_x    (q_x),
      .full     (q_full)
   );

   // back: polynomial, reciprocal, offset, saturation
   trt_back #(
      .POLY_DEGREE  (POLY_DEGREE),
      .LN_FRAC_BITS (LN_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (q_tag),
      .in_x       (q_x),
      .coef       (coef_ff),
      .out_valid  (rsp_strobe),
      .out_temp   (temp_raw),
      .out_status (rsp_status)
   );

   assign rsp_temp_centi_c = signed'(temp_raw);

`ifndef SYNTHESIS
   a_zero_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == trt_pkg::ST_ZERO) |-> (rsp_temp_centi_c == 0))
      else $error("zero-resistance result carries a temperature");

   a_npos_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == trt_pkg::ST_NPOS) |-> (rsp_temp_centi_c == 0))
      else $error("bad-polynomial result carries a temperature");

   a_sat_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == trt_pkg::ST_SAT)
      |-> (temp_raw == trt_pkg::TEMP_MAX))
      else $error("saturated result not at full scale");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("strobe right after reset");
`endif

endmodule

`default_nettype wire

/* src/trt_front.sv */
// ============================================================================
// trt_front - input classification and fixed-point natural log
// Registers the resistance, flags zero, and forms ln r through a pipeline of
// 32 squaring stages followed by the ln 2 scaling and rounding.
// ============================================================================
`default_nettype none

module trt_front #(
   parameter int LN_FRAC_BITS = trt_pkg::LN_FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire logic [trt_pkg::R_W-1:0]                in_r,
   output trt_pkg::tag_type                            out_tag,
   output logic [trt_pkg::XINT_W+LN_FRAC_BITS-1:0]     out_x
);

   localparam int XW = trt_pkg::XINT_W + LN_FRAC_BITS;
   localparam int NS = trt_pkg::LOG_STEPS;
   localparam int LW = 37;   // ln r in Q.32

   trt_pkg::tag_type           tag_ff  [0:NS];
   logic [31:0]                m_ff    [0:NS];
   logic [31:0]                frac_ff [0:NS];
   logic [trt_pkg::K_W-1:0]    k_ff    [0:NS];

   logic [trt_pkg::K_W-1:0]    k0_in;
   logic [31:0]                m0_in;
   trt_pkg::tag_type           tag0_in;

   // normalize: top set bit lands at bit 31
   always_comb begin
      k0_in = '0;
      for (int i = 0; i < trt_pkg::R_W; i++) begin
         if (in_r[i]) k0_in = trt_pkg::K_W'(i);
      end
      m0_in = 32'(in_r) << (5'd31 - k0_in);
      tag0_in.valid = in_valid;
      tag0_in.zero  = (in_r == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else begin
         tag_ff[0] <= tag0_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff[0]    <= m0_in;
      k_ff[0]    <= k0_in;
      frac_ff[0] <= '0;
   end

   for (genvar j = 0; j < NS; j++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] t;
      logic        bit_in;
      logic [31:0] m_in;
      always_comb begin
         sq     = m_ff[j] * m_ff[j];
         t      = sq[63:31];
         bit_in = t[32];
         m_in   = bit_in ? t[32:1] : t[31:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[j+1] <= '0;
         end else begin
            tag_ff[j+1] <= tag_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         m_ff[j+1]    <= m_in;
         frac_ff[j+1] <= {frac_ff[j][30:0], bit_in};
         k_ff[j+1]    <= k_ff[j];
      end
   end

   // ln r = k*ln2 + round(frac*ln2)
   trt_pkg::tag_type          tag_a_ff, tag_b_ff, tag_c_ff;
   logic [63:0]               prod_a_ff;
   logic [trt_pkg::K_W-1:0]   k_a_ff;
   logic [LW-1:0]             lnq_b_ff;
   logic [XW-1:0]             x_c_ff;
   logic [LW-1:0]             lnq_in;
   logic [64:0]               prod_rnd;
   logic [XW-1:0]             x_in;

   always_comb begin
      prod_rnd = 65'(prod_a_ff) + 65'h0_8000_0000;
      lnq_in   = LW'(k_a_ff) * LW'(trt_pkg::LN2_Q32) + LW'(prod_rnd[64:32]);
   end

   if (LN_FRAC_BITS >= 32) begin : g_x_full
      assign x_in = XW'(lnq_b_ff);
   end else begin : g_x_rnd
      logic [LW:0] lnr;
      assign lnr  = (LW+1)'(lnq_b_ff) + ((LW+1)'(1) << (31 - LN_FRAC_BITS));
      assign x_in = XW'(lnr >> (32 - LN_FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else begin
         tag_a_ff <= tag_ff[NS];
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= frac_ff[NS] * 64'(trt_pkg::LN2_Q32);
      k_a_ff    <= k_ff[NS];
      lnq_b_ff  <= lnq_in;
      x_c_ff    <= x_in;
   end

   assign out_tag = tag_c_ff;
   assign out_x   = x_c_ff;

endmodule

`default_nettype wire

/* src/trt_queue.sv */
// ============================================================================
// trt_queue - short queue between log front and polynomial back
// Small register FIFO; the head is presented whenever the queue holds data.
// ============================================================================
`default_nettype none

module trt_queue #(
   parameter int XW = trt_pkg::XINT_W + trt_pkg::LN_FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  trt_pkg::tag_type       in_tag,
   input  wire logic [XW-1:0]     in_x,
   input  wire logic              out_take,
   output trt_pkg::tag_type       out_tag,
   output logic [XW-1:0]          out_x,
   output logic                   full
);

   localparam int D  = trt_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(D);
   localparam int CW = $clog2(D + 1);

   logic [XW-1:0] x_mem    [0:D-1];
   logic          zero_mem [0:D-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   always_comb begin
      push      = in_tag.valid;
      pop       = out_take && (count_ff != '0);
      wr_ptr_in = push ? PW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CW'(count_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         x_mem[wr_ptr_ff]    <= in_x;
         zero_mem[wr_ptr_ff] <= in_tag.zero;
      end
   end

   always_comb begin
      out_tag.valid = (count_ff != '0);
      out_tag.zero  = zero_mem[rd_ptr_ff];
      out_x         = x_mem[rd_ptr_ff];
      full          = (count_ff == CW'(D));
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue overflow");
`endif

endmodule

`default_nettype wire

/* src/trt_back.sv */
// ============================================================================
// trt_back - Horner polynomial and reciprocal to hundredths of a degree
// Three stages per Horner step, then a pipelined restoring divider.
// ============================================================================
`default_nettype none

module trt_back #(
   parameter int POLY_DEGREE  = trt_pkg::POLY_DEGREE_DEF,
   parameter int LN_FRAC_BITS = trt_pkg::LN_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  trt_pkg::tag_type                          in_tag,
   input  wire logic [trt_pkg::XINT_W+LN_FRAC_BITS-1:0] in_x,
   input  trt_pkg::coef_bank_type                    coef,
   output logic                                      out_valid,
   output logic [trt_pkg::TEMP_W-1:0]                out_temp,
   output logic [trt_pkg::STAT_W-1:0]                out_status
);

   localparam int XW  = trt_pkg::XINT_W + LN_FRAC_BITS;
   localparam int D   = POLY_DEGREE;
   localparam int HW  = 31;                 // half of the magnitude
   localparam int PPW = HW + XW;            // partial product
   localparam int PW  = 2 * HW + XW + 1;    // full product plus carry
   localparam int AW  = trt_pkg::ACC_W;
   localparam int MW  = trt_pkg::MAG_W;
   localparam int QW  = trt_pkg::Q_W;
   localparam int RW  = MW + QW;            // remainder width
   localparam logic signed [AW-1:0] CAP_S = AW'(trt_pkg::ACC_CAP);

   function automatic logic signed [AW-1:0] coef_ext(input trt_pkg::coef_bank_type c,
                                                     input int idx);
      logic signed [AW-1:0] v;
      v = '0;
      if (idx < trt_pkg::NUM_COEF) v = AW'(signed'(c[idx[1:0]]));
      return v;
   endfunction

   // ---------------- Horner ----------------
   trt_pkg::tag_type        h_tag_ff [0:3*D];
   logic [XW-1:0]           h_x_ff   [0:3*D];
   logic signed [AW-1:0]    acc_ff   [0:D];
   logic [PPW-1:0]          ph_ff    [0:D-1];
   logic [PPW-1:0]          pl_ff    [0:D-1];
   logic                    neg_ff   [0:D-1];
   logic                    neg2_ff  [0:D-1];
   logic [MW-1:0]           rmag_ff  [0:D-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         h_tag_ff[0] <= '0;
      end else begin
         h_tag_ff[0] <= in_tag;
      end
   end

   always_ff @(posedge clock) begin
      h_x_ff[0] <= in_x;
      acc_ff[0] <= coef_ext(coef, D);
   end

   for (genvar s = 0; s < D; s++) begin : g_horner
      logic [MW-1:0]          mag;
      logic [PW-1:0]          prod;
      logic [PW-LN_FRAC_BITS-1:0] r;
      logic [MW-1:0]          rmag_in;
      logic signed [AW-1:0]   rs, sum, acc_in;

      always_comb begin
         mag  = acc_ff[s][AW-1] ? MW'(-acc_ff[s]) : MW'(acc_ff[s]);
         prod = PW'({ph_ff[s], {HW{1'b0}}}) + PW'(pl_ff[s])
                + (PW'(1) << (LN_FRAC_BITS - 1));
         r    = prod[PW-1:LN_FRAC_BITS];
         rmag_in = (|r[PW-LN_FRAC_BITS-1:MW]) ? trt_pkg::ACC_CAP : r[MW-1:0];
         rs   = neg2_ff[s] ? -AW'({2'b00, rmag_ff[s]}) : AW'({2'b00, rmag_ff[s]});
         sum  = rs + coef_ext(coef, D - 1 - s);
         if (sum > CAP_S)       acc_in = CAP_S;
         else if (sum < -CAP_S) acc_in = -CAP_S;
         else                   acc_in = sum;
      end

      for (genvar t = 0; t < 3; t++) begin : g_tag
         always_ff @(posedge clock) begin
            if (reset) begin
               h_tag_ff[3*s+t+1] <= '0;
            end else begin
               h_tag_ff[3*s+t+1] <= h_tag_ff[3*s+t];
            end
         end
         always_ff @(posedge clock) begin
            h_x_ff[3*s+t+1] <= h_x_ff[3*s+t];
         end
      end

      always_ff @(posedge clock) begin
         ph_ff[s]     <= PPW'(mag[MW-1:HW]) * PPW'(h_x_ff[3*s]);
         pl_ff[s]     <= PPW'(mag[HW-1:0]) * PPW'(h_x_ff[3*s]);
         neg_ff[s]    <= acc_ff[s][AW-1];
         rmag_ff[s]   <= rmag_in;
         neg2_ff[s]   <= neg_ff[s];
         acc_ff[s+1]  <= acc_in;
      end
   end

   // ---------------- reciprocal ----------------
   trt_pkg::tag_type    n_tag_ff, v_tag_ff;
   logic                n_bad_ff, v_bad_ff;
   logic [MW-1:0]       n_acc_ff, v_acc_ff;
   logic [MW-1:0]       n_num_ff;
   logic                v_ovf_ff;
   logic [RW-1:0]       v_rem_ff;

   trt_pkg::tag_type    d_tag_ff [0:QW];
   logic                d_bad_ff [0:QW];
   logic                d_ovf_ff [0:QW];
   logic [MW-1:0]       d_acc_ff [0:QW];
   logic [RW-1:0]       d_rem_ff [0:QW];
   logic [QW-1:0]       d_q_ff   [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         n_tag_ff <= '0;
         v_tag_ff <= '0;
      end else begin
         n_tag_ff <= h_tag_ff[3*D];
         v_tag_ff <= n_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_bad_ff <= (acc_ff[D] <= 0);
      n_acc_ff <= acc_ff[D][MW-1:0];
      n_num_ff <= MW'(trt_pkg::INV_NUM) + {1'b0, acc_ff[D][MW-1:1]};
      v_bad_ff <= n_bad_ff;
      v_acc_ff <= n_acc_ff;
      v_ovf_ff <= (RW'(n_num_ff) >= {n_acc_ff, {QW{1'b0}}});
      v_rem_ff <= RW'(n_num_ff);
   end

   assign d_tag_ff[0] = v_tag_ff;
   assign d_bad_ff[0] = v_bad_ff;
   assign d_ovf_ff[0] = v_ovf_ff;
   assign d_acc_ff[0] = v_acc_ff;
   assign d_rem_ff[0] = v_rem_ff;
   assign d_q_ff[0]   = '0;

   for (genvar n = 0; n < QW; n++) begin : g_div
      logic [RW:0] diff;
      always_comb begin
         diff = {1'b0, d_rem_ff[n]} - ((RW+1)'(d_acc_ff[n]) << (QW - 1 - n));
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            d_tag_ff[n+1] <= '0;
         end else begin
            d_tag_ff[n+1] <= d_tag_ff[n];
         end
      end
      always_ff @(posedge clock) begin
         d_bad_ff[n+1] <= d_bad_ff[n];
         d_ovf_ff[n+1] <= d_ovf_ff[n];
         d_acc_ff[n+1] <= d_acc_ff[n];
         d_rem_ff[n+1] <= diff[RW] ? d_rem_ff[n] : diff[RW-1:0];
         d_q_ff[n+1]   <= {d_q_ff[n][QW-2:0], ~diff[RW]};
      end
   end

   // ---------------- result ----------------
   logic                        valid_ff;
   logic [trt_pkg::TEMP_W-1:0]  temp_ff, temp_in;
   trt_pkg::status_type         status_ff, status_in;

   always_comb begin
      if (d_tag_ff[QW].zero) begin
         temp_in = '0;   status_in = trt_pkg::ST_ZERO;
      end else if (d_bad_ff[QW]) begin
         temp_in = '0;   status_in = trt_pkg::ST_NPOS;
      end else if (d_ovf_ff[QW] || (d_q_ff[QW] > trt_pkg::Q_SAT)) begin
         temp_in = trt_pkg::TEMP_MAX;   status_in = trt_pkg::ST_SAT;
      end else begin
         temp_in = d_q_ff[QW] - trt_pkg::KELVIN_OFS;   status_in = trt_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= d_tag_ff[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff   <= temp_in;
      status_ff <= status_in;
   end

   assign out_valid  = valid_ff;
   assign out_temp   = temp_ff;
   assign out_status = status_ff;

endmodule

`default_nettype wire
